### src/aes_var_pkg.sv
// Package with field arithmetic, S-box tables and round helpers for the cipher.
`timescale 1ns / 1ps

package aes_var_pkg;

    // Number of cipher rounds and the field reduction byte.
    localparam int  NumRounds = 10;
    localparam logic [7:0] GfReduce = 8'hE7;

    // Command codes carried with each input beat.
    localparam logic CmdEncrypt = 1'b0;
    localparam logic CmdDecrypt = 1'b1;

    // Configuration register indexes.
    localparam logic CfgKeyHigh = 1'b0;
    localparam logic CfgKeyLow  = 1'b1;

    typedef logic [7:0] sbox_t [256];
    typedef logic [7:0] rcon_t [NumRounds + 1];

    // Round constants over the 0x1E7 field.
    localparam rcon_t RoundConst = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                     8'h20, 8'h40, 8'h80, 8'hE7, 8'h29};

    // Multiply by x in the field.
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GfReduce : 8'h00);
    endfunction

    // Full field product; used only to build the tables at elaboration.
    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc = acc ^ x;
            x = xtime(x);
        end
        return acc;
    endfunction

    // Field inverse as b^254; zero maps to zero.
    function automatic logic [7:0] ginv(input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h01;
        p = b;
        for (int e = 0; e < 8; e++)
        begin
            if (e != 0)
                r = gmul(r, p);
            p = gmul(p, p);
        end
        return r;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic sbox_t build_fwd();
        sbox_t t;
        logic [7:0] s;
        for (int v = 0; v < 256; v++)
        begin
            s = ginv(8'(v));
            t[v] = s ^ rotl8(s, 1) ^ rotl8(s, 2) ^ rotl8(s, 3) ^ rotl8(s, 4) ^ 8'h63;
        end
        return t;
    endfunction

    function automatic sbox_t build_inv();
        sbox_t t;
        logic [7:0] a;
        logic [7:0] v8;
        for (int v = 0; v < 256; v++)
        begin
            v8 = 8'(v);
            a = rotl8(v8, 1) ^ rotl8(v8, 3) ^ rotl8(v8, 6) ^ 8'h05;
            t[v] = ginv(a);
        end
        return t;
    endfunction

    localparam sbox_t SboxFwd = build_fwd();
    localparam sbox_t SboxInv = build_inv();

    // Byte i of a 128-bit state, byte 0 in the top bits.
    function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
        return s[127 - 8 * i -: 8];
    endfunction

    // ShiftRows followed by SubBytes.
    function automatic logic [127:0] shift_sub_fwd(input logic [127:0] s);
        logic [127:0] t;
        for (int i = 0; i < 16; i++)
            t[127 - 8 * i -: 8] = SboxFwd[get_byte(s, (i + 4 * (i & 3)) & 15)];
        return t;
    endfunction

    // Inverse ShiftRows followed by inverse SubBytes.
    function automatic logic [127:0] shift_sub_inv(input logic [127:0] s);
        logic [127:0] t;
        for (int i = 0; i < 16; i++)
            t[127 - 8 * i -: 8] = SboxInv[get_byte(s, (i - 4 * (i & 3)) & 15)];
        return t;
    endfunction

    // Forward MixColumns with coefficients {2,3,1,1}.
    function automatic logic [127:0] mix_fwd(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                a0 = get_byte(s, 4 * c + i);
                a1 = get_byte(s, 4 * c + ((i + 1) & 3));
                a2 = get_byte(s, 4 * c + ((i + 2) & 3));
                a3 = get_byte(s, 4 * c + ((i + 3) & 3));
                t[127 - 8 * (4 * c + i) -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            end
        end
        return t;
    endfunction

    // Constant products for the inverse MixColumns.
    function automatic logic [7:0] mul_inv(input logic [1:0] k, input logic [7:0] a);
        logic [7:0] x1, x2, x3;
        logic [7:0] r;
        x1 = xtime(a);
        x2 = xtime(x1);
        x3 = xtime(x2);
        case (k)
            2'd0:    r = x3 ^ x2 ^ x1;
            2'd1:    r = x3 ^ x1 ^ a;
            2'd2:    r = x3 ^ x2 ^ a;
            default: r = x3 ^ a;
        endcase
        return r;
    endfunction

    // Inverse MixColumns with coefficients {14,11,13,9}.
    function automatic logic [127:0] mix_inv(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] acc;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++)
                    acc = acc ^ mul_inv(2'((j - i) & 3), get_byte(s, 4 * c + j));
                t[127 - 8 * (4 * c + i) -: 8] = acc;
            end
        end
        return t;
    endfunction

    // One key schedule step from the previous round key.
    function automatic logic [127:0] key_step(input logic [127:0] p, input logic [7:0] rc);
        logic [31:0] tw;
        logic [31:0] w0, w1, w2, w3;
        tw = {SboxFwd[get_byte(p, 13)] ^ rc, SboxFwd[get_byte(p, 14)],
              SboxFwd[get_byte(p, 15)], SboxFwd[get_byte(p, 12)]};
        w0 = p[127:96] ^ tw;
        w1 = p[95:64] ^ w0;
        w2 = p[63:32] ^ w1;
        w3 = p[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

### src/aes128_variant_block_cipher.sv
// Top level: pipelined AES-128 style cipher over the 0x1E7 field, ECB mode.
//
// Input beats arrive on s_axis: tdata carries cmd (0 encrypt, 1 decrypt) and
// the 128-bit block. Results leave on m_axis, one beat per input beat, in order.
// The key is written through cfg_we / cfg_addr / cfg_data: index 0 is the high
// key half, index 1 the low half. Each write starts the key schedule, which
// loads the key and then fills one round key a cycle; s_axis_tready stays
// low meanwhile.
// The datapath has 11 register stages: an initial key add and one stage per
// round, each holding one round (S-box lookup, column mix but in the last, key add).
// m_axis_tvalid rises once an accepted beat has passed all stage registers,
// st_reg[0] to st_reg[10]. A new block can enter every cycle when not stalled
// and no key schedule runs, so the sustained rate is one block per cycle.
// Reset loads the all-zero key and runs the schedule; the block is ready once
// the schedule finishes. When m_axis_tready is low with a result waiting,
// the whole pipeline holds and s_axis_tready drops; nothing is lost.
`timescale 1ns / 1ps

module aes128_variant_block_cipher
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0: cmd[0], block_high[64:1], block_low[128:65], zero pad.
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0: result_high[63:0], result_low[127:64].
    output logic [127:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [63:0]  cfg_data
);
    import aes_var_pkg::*;

    localparam int Stages = NumRounds + 1;

    logic [63:0]  key_high_reg, key_low_reg;
    logic         busy_reg;
    logic [3:0]   kcnt_reg;
    logic [127:0] kprev_reg;
    logic [127:0] rk_reg [Stages];
    logic [127:0] knew;

    logic [127:0] st_reg  [Stages];
    logic [127:0] st_next [Stages];
    logic         vld_reg [Stages];
    logic         cmd_reg [Stages];
    logic         advance;

    // Key registers and the key schedule sequencer.
    assign knew = key_step(kprev_reg, RoundConst[kcnt_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            busy_reg     <= 1'b1;
            kcnt_reg     <= 4'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CfgKeyHigh)
                key_high_reg <= cfg_data;
            else
                key_low_reg <= cfg_data;
            busy_reg <= 1'b1;
            kcnt_reg <= 4'd0;
        end
        else if (busy_reg)
        begin
            if (kcnt_reg == 4'(NumRounds))
                busy_reg <= 1'b0;
            kcnt_reg <= kcnt_reg + 4'd1;
        end
    end

    // Round key store: entry 0 is the key itself, later entries one per step.
    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_we)
        begin
            if (kcnt_reg == 4'd0)
            begin
                kprev_reg <= {key_high_reg, key_low_reg};
                rk_reg[0] <= {key_high_reg, key_low_reg};
            end
            else
            begin
                kprev_reg <= knew;
                rk_reg[kcnt_reg] <= knew;
            end
        end
    end

    // The pipeline moves whenever the output stage is empty or being drained.
    assign advance       = !vld_reg[Stages - 1] || m_axis_tready;
    assign s_axis_tready = advance && !busy_reg;
    assign m_axis_tvalid = vld_reg[Stages - 1];
    assign m_axis_tdata  = {st_reg[Stages - 1][63:0], st_reg[Stages - 1][127:64]};

    // Initial key add.
    assign st_next[0] = {s_axis_tdata[64:1], s_axis_tdata[128:65]} ^
                        ((s_axis_tdata[0] == CmdDecrypt) ? rk_reg[NumRounds] : rk_reg[0]);

    // One full round per stage.
    for (genvar g = 1; g < Stages; g++)
    begin : g_round
        logic [127:0] enc_sub, dec_sub;
        logic [127:0] enc_out, dec_out;
        always_comb
        begin
            enc_sub = shift_sub_fwd(st_reg[g - 1]);
            dec_sub = shift_sub_inv(st_reg[g - 1]) ^ rk_reg[NumRounds - g];
            if (g == NumRounds)
            begin
                enc_out = enc_sub ^ rk_reg[g];
                dec_out = dec_sub;
            end
            else
            begin
                enc_out = mix_fwd(enc_sub) ^ rk_reg[g];
                dec_out = mix_inv(dec_sub);
            end
            st_next[g] = (cmd_reg[g - 1] == CmdDecrypt) ? dec_out : enc_out;
        end
    end

    // Valid and command bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Stages; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= s_axis_tvalid && s_axis_tready;
            for (int i = 1; i < Stages; i++)
                vld_reg[i] <= vld_reg[i - 1];
        end
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_reg[0] <= s_axis_tdata[0];
            for (int i = 0; i < Stages; i++)
                st_reg[i] <= st_next[i];
            for (int i = 1; i < Stages; i++)
                cmd_reg[i] <= cmd_reg[i - 1];
        end
    end

endmodule
